// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define FWPB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication with a fixed delay in cycles
`define FWPB_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ----- rtl/fwpb_pkg.sv -----
// shared constants and pixel functions for the frame over wallpaper blend
// no dependencies
`default_nettype none

package fwpb_pkg;

	localparam int FMT_W = 2;
	localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd0;
	localparam logic [FMT_W-1:0] FMT_RGB555 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_BGRA32 = 2'd2;
	localparam int FMT_WIDE_BIT = 1;

	localparam int CH_W = 8;
	localparam int PROD_W = 2 * CH_W;
	localparam int WORD_W = 32;
	localparam logic [CH_W-1:0] ALPHA_FULL = 8'hFF;
	localparam logic [PROD_W-1:0] ROUND_BIAS = 16'd127;
	// x / 255 == (x * 32897) >> 23 for any 16-bit x
	localparam logic [PROD_W-1:0] RECIP_255 = 16'd32897;
	localparam int RECIP_SHIFT = 23;

	// x * 255 / 31 == 8x + floor(7x / 31)
	function automatic logic [CH_W-1:0] expand5(input logic [4:0] x);
		logic [2:0] k;
		k = {2'b0, x >= 5'd5} + {2'b0, x >= 5'd9} + {2'b0, x >= 5'd14}
			+ {2'b0, x >= 5'd18} + {2'b0, x >= 5'd23} + {2'b0, x >= 5'd27}
			+ {2'b0, x >= 5'd31};
		return {x, 3'b000} + {5'b0, k};
	endfunction

	// x * 255 / 63 == 4x + floor(x / 21)
	function automatic logic [CH_W-1:0] expand6(input logic [5:0] x);
		logic [1:0] k;
		k = {1'b0, x >= 6'd21} + {1'b0, x >= 6'd42} + {1'b0, x == 6'd63};
		return {x, 2'b00} + {6'b0, k};
	endfunction

	function automatic logic [WORD_W-1:0] pack_rgb(
		input logic [FMT_W-1:0] fmt,
		input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] g,
		input logic [CH_W-1:0] b
	);
		logic [WORD_W-1:0] w;
		if (fmt[FMT_WIDE_BIT]) begin
			w = {ALPHA_FULL, r, g, b};
		end else if (fmt == FMT_RGB555) begin
			w = {17'b0, r[7:3], g[7:3], b[7:3]};
		end else begin
			w = {16'b0, r[7:3], g[7:2], b[7:3]};
		end
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/fwpb_blend_lane.sv -----
// one color channel of the alpha blend, (f*a + d*(255-a) + 127) / 255
// products in the first stage, bias and divide by reciprocal in the second; uses fwpb_pkg
`default_nettype none

module fwpb_blend_lane (
	input  wire logic                   clk,
	input  wire logic [fwpb_pkg::CH_W-1:0] fore,
	input  wire logic [fwpb_pkg::CH_W-1:0] back,
	input  wire logic [fwpb_pkg::CH_W-1:0] alpha,
	output logic      [fwpb_pkg::CH_W-1:0] mixed
);
	import fwpb_pkg::*;

	logic [PROD_W-1:0] prod_f_s2;
	logic [PROD_W-1:0] prod_d_s2;
	logic [PROD_W-1:0] sum;
	logic [2*PROD_W-1:0] scaled;
	logic [CH_W-1:0] mixed_s3;

	// max sum is 255*255 + 127, fits in 16 bits
	assign sum = prod_f_s2 + prod_d_s2 + ROUND_BIAS;
	assign scaled = sum * RECIP_255;

	always_ff @(posedge clk) begin
		prod_f_s2 <= fore * alpha;
		prod_d_s2 <= back * (ALPHA_FULL - alpha);
		mixed_s3 <= scaled[RECIP_SHIFT +: CH_W];
	end

	assign mixed = mixed_s3;

endmodule

`default_nettype wire

// ----- rtl/frame_over_wallpaper_pixel_blend.sv -----
// frame over wallpaper pixel blend: one pixel taken per clock, busy stays low
// a pixel accepted at an edge passes through the stage 1 registers, the lane product and
// divide registers and the word register, and done is strobed together with its pixel word
// four register stages: expand, multiply, divide by 255, pack
// reset clears the stage valid bits and sets the pixel format to rgb565
// the receiver cannot stall, so no item is ever held back; uses fwpb_pkg and fwpb_blend_lane
`default_nettype none
`include "assert_macros.svh"

module frame_over_wallpaper_pixel_blend (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [fwpb_pkg::FMT_W-1:0]  cfg_wr_data,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [fwpb_pkg::CH_W-1:0]   back_red,
	input  wire logic [fwpb_pkg::CH_W-1:0]   back_green,
	input  wire logic [fwpb_pkg::CH_W-1:0]   back_blue,
	input  wire logic                        frame_covers,
	input  wire logic [fwpb_pkg::CH_W-1:0]   frame_red,
	input  wire logic [fwpb_pkg::CH_W-1:0]   frame_green,
	input  wire logic [fwpb_pkg::CH_W-1:0]   frame_blue,
	input  wire logic [fwpb_pkg::CH_W-1:0]   frame_alpha,
	output logic                             done,
	output logic [fwpb_pkg::WORD_W-1:0]      pixel_word
);
	import fwpb_pkg::*;

	logic [FMT_W-1:0] fmt_q;

	logic [CH_W-1:0] dst_r, dst_g, dst_b;

	logic vld_s1, vld_s2, vld_s3;
	logic [FMT_W-1:0] fmt_s1, fmt_s2, fmt_s3;
	logic [CH_W-1:0] fr_s1, fg_s1, fb_s1;
	logic [CH_W-1:0] dr_s1, dg_s1, db_s1;
	logic [CH_W-1:0] a_s1;
	logic [CH_W-1:0] mr, mg, mb;

	logic done_q;
	logic [WORD_W-1:0] word_q;

	assign busy = 1'b0;

	// packed wallpaper expanded back to 8 bits; exact in 32-bit mode
	always_comb begin
		if (fmt_q[FMT_WIDE_BIT]) begin
			dst_r = back_red;
			dst_g = back_green;
			dst_b = back_blue;
		end else if (fmt_q == FMT_RGB555) begin
			dst_r = expand5(back_red[7:3]);
			dst_g = expand5(back_green[7:3]);
			dst_b = expand5(back_blue[7:3]);
		end else begin
			dst_r = expand5(back_red[7:3]);
			dst_g = expand6(back_green[7:2]);
			dst_b = expand5(back_blue[7:3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGB565;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				fmt_q <= cfg_wr_data;
			end
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	// alpha 0 or no frame blends to the wallpaper, alpha 255 to the frame color
	always_ff @(posedge clk) begin
		fmt_s1 <= fmt_q;
		fr_s1 <= frame_red;
		fg_s1 <= frame_green;
		fb_s1 <= frame_blue;
		dr_s1 <= dst_r;
		dg_s1 <= dst_g;
		db_s1 <= dst_b;
		a_s1 <= frame_covers ? frame_alpha : '0;
		fmt_s2 <= fmt_s1;
		fmt_s3 <= fmt_s2;
		word_q <= pack_rgb(fmt_s3, mr, mg, mb);
	end

	fwpb_blend_lane u_lane_r (.clk(clk), .fore(fr_s1), .back(dr_s1), .alpha(a_s1), .mixed(mr));
	fwpb_blend_lane u_lane_g (.clk(clk), .fore(fg_s1), .back(dg_s1), .alpha(a_s1), .mixed(mg));
	fwpb_blend_lane u_lane_b (.clk(clk), .fore(fb_s1), .back(db_s1), .alpha(a_s1), .mixed(mb));

	assign done = done_q;
	assign pixel_word = word_q;

	`FWPB_ASSERT_DLY(a_item_done, start && !busy, 4, done, "accepted item not delivered")
	`FWPB_ASSERT_DLY(a_no_extra, !(start && !busy), 4, !done, "result without an accepted item")
	`FWPB_ASSERT(a_word_form, !done || !(|pixel_word[31:16]) || &pixel_word[31:24], "bad word")

endmodule

`default_nettype wire

// ----- tb/frame_over_wallpaper_pixel_blend_tb.sv -----
// testbench for frame_over_wallpaper_pixel_blend: directed and random pixels in every format,
// checked against a scoreboard class that predicts the packed pixel word
// depends on fwpb_pkg and the rtl of the blend block
`default_nettype none

module frame_over_wallpaper_pixel_blend_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fwpb_pkg::*;

	localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;
	localparam int PIPE_DEPTH = 3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 125;
	localparam int PAUSE_AT = 60;
	localparam logic [CH_W-1:0] CH_MAX = 8'hFF;
	localparam logic [CH_W-1:0] CH_MIN = 8'h00;

	typedef struct packed {
		logic [CH_W-1:0] back_red;
		logic [CH_W-1:0] back_green;
		logic [CH_W-1:0] back_blue;
		logic            frame_covers;
		logic [CH_W-1:0] frame_red;
		logic [CH_W-1:0] frame_green;
		logic [CH_W-1:0] frame_blue;
		logic [CH_W-1:0] frame_alpha;
	} pixel_in_t;

	class pixel_blend_checker;
		logic [FMT_W-1:0] fmt;
		logic [WORD_W-1:0] expected_words[$];
		int mismatches;

		function new();
			fmt = FMT_RGB565;
			mismatches = 0;
		endfunction

		function logic [WORD_W-1:0] pack_word(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b);
			if (fmt[1]) begin
				return {8'hFF, r, g, b};
			end
			if (fmt == FMT_RGB555) begin
				return {17'b0, r[7:3], g[7:3], b[7:3]};
			end
			return {16'b0, r[7:3], g[7:2], b[7:3]};
		endfunction

		function int unsigned widen(int unsigned x, int unsigned top);
			return x * 255 / top;
		endfunction

		function int unsigned mix(int unsigned f, int unsigned d, int unsigned a);
			return (f * a + d * (255 - a) + 127) / 255;
		endfunction

		function void note_pixel(pixel_in_t p);
			logic [WORD_W-1:0] w;
			int unsigned dr, dg, db, a;
			w = pack_word(p.back_red, p.back_green, p.back_blue);
			a = p.frame_alpha;
			if (p.frame_covers && a != 0) begin
				if (a == 255) begin
					w = pack_word(p.frame_red, p.frame_green, p.frame_blue);
				end else begin
					if (fmt[1]) begin
						dr = w[23:16];
						dg = w[15:8];
						db = w[7:0];
					end else if (fmt == FMT_RGB555) begin
						dr = widen(w[14:10], 31);
						dg = widen(w[9:5], 31);
						db = widen(w[4:0], 31);
					end else begin
						dr = widen(w[15:11], 31);
						dg = widen(w[10:5], 63);
						db = widen(w[4:0], 31);
					end
					w = pack_word(CH_W'(mix(p.frame_red, dr, a)),
						CH_W'(mix(p.frame_green, dg, a)), CH_W'(mix(p.frame_blue, db, a)));
				end
			end
			expected_words.push_back(w);
		endfunction

		function void check_word(logic [WORD_W-1:0] got);
			logic [WORD_W-1:0] want;
			if (expected_words.size() == 0) begin
				$error("pixel_word: expected none, actual 0x%08h", got);
				mismatches++;
				return;
			end
			want = expected_words.pop_front();
			if (got !== want) begin
				$error("pixel_word: expected 0x%08h, actual 0x%08h", want, got);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [FMT_W-1:0] cfg_wr_data;
	logic start;
	logic busy;
	logic [CH_W-1:0] back_red, back_green, back_blue;
	logic frame_covers;
	logic [CH_W-1:0] frame_red, frame_green, frame_blue, frame_alpha;
	logic done;
	logic [WORD_W-1:0] pixel_word;
	int cycles = 0;

	pixel_blend_checker sb = new();

	localparam logic [FMT_W-1:0] PHASE_FMT [6] = '{FMT_RGB555, FMT_BGRA32, FMT_RGB565,
		FMT_SPARE, FMT_BGRA32, FMT_RGB565};
	localparam int PHASE_IDLE [6] = '{0, 83, 6, 0, 83, 6};
	localparam logic [FMT_W-1:0] DIRECTED_FMT [4] = '{FMT_RGB565, FMT_RGB555, FMT_BGRA32,
		FMT_SPARE};

	frame_over_wallpaper_pixel_blend uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.start       (start),
		.busy        (busy),
		.back_red    (back_red),
		.back_green  (back_green),
		.back_blue   (back_blue),
		.frame_covers(frame_covers),
		.frame_red   (frame_red),
		.frame_green (frame_green),
		.frame_blue  (frame_blue),
		.frame_alpha (frame_alpha),
		.done        (done),
		.pixel_word  (pixel_word)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && busy === 1'b0) begin
				sb.note_pixel('{back_red, back_green, back_blue, frame_covers,
					frame_red, frame_green, frame_blue, frame_alpha});
			end
			if (done === 1'b1) begin
				sb.check_word(pixel_word);
			end
		end
	end

	task automatic drive_pixel(pixel_in_t p);
		start <= 1'b1;
		back_red <= p.back_red;
		back_green <= p.back_green;
		back_blue <= p.back_blue;
		frame_covers <= p.frame_covers;
		frame_red <= p.frame_red;
		frame_green <= p.frame_green;
		frame_blue <= p.frame_blue;
		frame_alpha <= p.frame_alpha;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic hold_off(int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// stop sending and wait for every pending pixel word
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_words.size() != 0) @(posedge clk);
	endtask

	task automatic write_format(logic [FMT_W-1:0] f);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= f;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.fmt = f;
		@(posedge clk);
	endtask

	function automatic pixel_in_t random_pixel();
		pixel_in_t p;
		int sel;
		p.back_red = CH_W'($urandom_range(255));
		p.back_green = CH_W'($urandom_range(255));
		p.back_blue = CH_W'($urandom_range(255));
		p.frame_covers = $urandom_range(9) != 0;
		p.frame_red = CH_W'($urandom_range(255));
		p.frame_green = CH_W'($urandom_range(255));
		p.frame_blue = CH_W'($urandom_range(255));
		sel = $urandom_range(9);
		if (sel < 2) begin
			p.frame_alpha = CH_MIN;
		end else if (sel < 4) begin
			p.frame_alpha = CH_MAX;
		end else if (sel == 4) begin
			p.frame_alpha = $urandom_range(1) ? 8'd1 : 8'd254;
		end else begin
			p.frame_alpha = CH_W'($urandom_range(255));
		end
		return p;
	endfunction

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= FMT_RGB565;
		start <= 1'b0;
		back_red <= CH_MIN;
		back_green <= CH_MIN;
		back_blue <= CH_MIN;
		frame_covers <= 1'b0;
		frame_red <= CH_MIN;
		frame_green <= CH_MIN;
		frame_blue <= CH_MIN;
		frame_alpha <= CH_MIN;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_FMT[i]) begin
			write_format(DIRECTED_FMT[i]);
			// frame absent, frame fields ignored
			drive_pixel('{CH_MIN, CH_MIN, CH_MIN, 1'b0, CH_MAX, CH_MAX, CH_MAX, CH_MAX});
			// transparent frame keeps wallpaper
			drive_pixel('{CH_MAX, CH_MAX, CH_MAX, 1'b1, CH_MIN, CH_MIN, CH_MIN, CH_MIN});
			// opaque frame replaces wallpaper
			drive_pixel('{CH_MIN, CH_MIN, CH_MIN, 1'b1, CH_MAX, CH_MAX, CH_MAX, CH_MAX});
			drive_pixel('{CH_MAX, CH_MAX, CH_MAX, 1'b1, CH_MIN, CH_MIN, CH_MIN, 8'd1});
			drive_pixel('{8'h5A, 8'hA5, 8'h3C, 1'b1, CH_MAX, CH_MIN, 8'h81, 8'd254});
			drive_pixel('{8'hC3, 8'h7E, 8'h19, 1'b1, 8'h24, 8'hDB, 8'h66, 8'd128});
			settle();
		end

		foreach (PHASE_FMT[ph]) begin
			write_format(PHASE_FMT[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PAUSE_AT) begin
					settle();
				end
				hold_off(PHASE_IDLE[ph]);
				drive_pixel(random_pixel());
			end
			settle();
		end

		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
